// ----- src/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// shared widths, codes and helpers of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    // default heap depth in 16-byte units
    localparam int HEAP_UNITS_DEF = 65536;
    // largest unit count that the allocator uses; a deeper heap is capped to it
    localparam int UNIT_SPAN      = 65536;
    localparam int UNIT_SHIFT     = 4;

    localparam int REG_W    = 17;
    localparam int OP_W     = 2;
    localparam int SIZE_W   = 21;
    localparam int OFF_W    = 21;
    localparam int STATUS_W = 2;
    localparam int COPY_W   = 20;
    localparam int HDR_W    = 18;
    localparam int UNITS_W  = 18;
    localparam int CNT_W    = 17;
    localparam int TDATA_W  = 48;
    localparam int OUT_W    = STATUS_W + OFF_W + COPY_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [REG_W-1:0] LIMIT_RST = 17'd65536;
    localparam logic [REG_W-1:0] GROW_RST  = 17'd4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROW_MIN   = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_NULL  = 2'd2
    } status_t;

    // request bytes to units, header included, zero taken as one byte
    function automatic logic [UNITS_W-1:0] units_of(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s;
        logic [SIZE_W:0]   sum;
        s   = (size == '0) ? SIZE_W'(1) : size;
        sum = {1'b0, s} + (SIZE_W+1)'(31);
        return sum[SIZE_W:UNIT_SHIFT];
    endfunction

    // header unit to payload byte offset
    function automatic logic [OFF_W-1:0] off_of(input logic [CNT_W-1:0] at);
        logic [CNT_W-1:0] nxt;
        nxt = at + CNT_W'(1);
        return {nxt, 4'b0000};
    endfunction

endpackage

// ----- src/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over a heap of 16-byte units with one header per block
// ----------------------------------------------------------------------------
// One item at a time: s_tready is high only while the sequencer is idle. An
// allocate walks the block headers from unit 0, one header per cycle out of
// the header memory, and falls back to a bump at the heap top. A free reads
// the header, writes it back and hands on the result; a resize that keeps its
// block reads the header and hands on the result; a moving resize reads the
// old header, runs an allocate and then releases the old block. The header
// memory (one write port, one registered read port) is what sets the pace. It
// needs no clearing pass: the walk reads only headers that were written, but a
// free or resize reads whatever unit its pointer names. The finished result
// sits in an output register, so a stalled m_tready holds the next result
// inside the block until it drains.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffha_pkg::TDATA_W-1:0]   s_tdata,    // op[1:0], size_bytes[22:2], block_offset[43:23]
    // result item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ffha_pkg::TDATA_W-1:0]   m_tdata,    // status[1:0], result_offset[22:2], copy_bytes[42:23]
    // configuration writes
    input  logic                           cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffha_pkg::REG_W-1:0]     cfg_wdata
);

    localparam int AW  = $clog2(HEAP_UNITS);
    localparam int CAP = (HEAP_UNITS > ffha_pkg::UNIT_SPAN) ? ffha_pkg::UNIT_SPAN : HEAP_UNITS;
    localparam logic [ffha_pkg::CNT_W-1:0] CAP_UNITS = ffha_pkg::CNT_W'(CAP);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,  // waiting for an item
        S_HDR     = 6'b000010,  // header of the named block is in rd_data_reg
        S_SCAN    = 6'b000100,  // header at p_reg is in rd_data_reg
        S_BUMP    = 6'b001000,  // new block at the heap top
        S_RELEASE = 6'b010000,  // free the old block of a moving resize
        S_RESP    = 6'b100000   // hand result to the output register
    } state_t;

    state_t state_reg, state_next;

    // request held during the work
    logic [ffha_pkg::OP_W-1:0]     op_reg, op_next;
    logic [ffha_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [ffha_pkg::OFF_W-1:0]    off_reg, off_next;
    logic [ffha_pkg::CNT_W-1:0]    u_reg, u_next;
    logic [ffha_pkg::UNITS_W-1:0]  units_reg, units_next;
    logic [ffha_pkg::CNT_W-1:0]    p_reg, p_next;
    logic [ffha_pkg::HDR_W-1:0]    hdr_reg, hdr_next;
    logic                          moving_reg, moving_next;

    // pending result
    logic [ffha_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ffha_pkg::OFF_W-1:0]    res_off_reg, res_off_next;
    logic [ffha_pkg::COPY_W-1:0]   res_copy_reg, res_copy_next;

    // heap state and configuration
    logic [ffha_pkg::CNT_W-1:0]    heap_top_reg, heap_top_next;
    logic [ffha_pkg::CNT_W-1:0]    reserved_end_reg, reserved_end_next;
    logic [ffha_pkg::REG_W-1:0]    limit_reg, limit_next;
    logic [ffha_pkg::REG_W-1:0]    grow_reg, grow_next;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [ffha_pkg::OUT_W-1:0]    m_data_reg, m_data_next;

    // header memory
    logic [ffha_pkg::HDR_W-1:0]    hdr_mem [HEAP_UNITS];
    logic [ffha_pkg::HDR_W-1:0]    rd_data_reg;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [ffha_pkg::HDR_W-1:0]    mem_wdata;
    logic [AW-1:0]                 mem_raddr;

    // input fields
    logic [ffha_pkg::OP_W-1:0]     in_op;
    logic [ffha_pkg::SIZE_W-1:0]   in_size;
    logic [ffha_pkg::OFF_W-1:0]    in_off;
    logic [ffha_pkg::CNT_W-1:0]    in_u;
    logic                          in_ptr_ok;
    logic                          accept;

    // shared datapath
    logic [ffha_pkg::CNT_W-1:0]    lim;
    logic [ffha_pkg::CNT_W-1:0]    cur_bsz;
    logic                          cur_used;
    logic [ffha_pkg::CNT_W:0]      scan_next;
    logic [ffha_pkg::CNT_W+1:0]    need_end;
    logic                          bump_ok;
    logic [ffha_pkg::CNT_W:0]      grow_sum;
    logic [ffha_pkg::CNT_W+1:0]    grow_cand;
    logic [ffha_pkg::CNT_W-1:0]    grow_val;
    logic [ffha_pkg::CNT_W-1:0]    old_less;
    logic [ffha_pkg::OFF_W-1:0]    usable;
    logic                          start_alloc;

    assign in_op   = s_tdata[1:0];
    assign in_size = s_tdata[22:2];
    assign in_off  = s_tdata[43:23];
    // header sits one unit below the payload
    assign in_u      = in_off[ffha_pkg::OFF_W-1:ffha_pkg::UNIT_SHIFT] - ffha_pkg::CNT_W'(1);
    assign in_ptr_ok = (in_off[3:0] == 4'd0) && (in_off != '0) && (in_u < heap_top_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(ffha_pkg::TDATA_W - ffha_pkg::OUT_W)'(0), m_data_reg};

    // limit above the memory depth acts as the depth
    assign lim = (limit_reg > CAP_UNITS) ? CAP_UNITS : limit_reg;

    // scan step
    assign cur_bsz   = rd_data_reg[ffha_pkg::HDR_W-1:1];
    assign cur_used  = rd_data_reg[0];
    assign scan_next = {1'b0, p_reg} + {1'b0, cur_bsz};

    // bump and reservation growth
    assign need_end  = {2'b00, heap_top_reg} + {1'b0, units_reg};
    assign bump_ok   = (need_end <= {2'b00, lim});
    assign grow_sum  = {1'b0, reserved_end_reg} + {1'b0, grow_reg};
    assign grow_cand = (need_end > {1'b0, grow_sum}) ? need_end : {1'b0, grow_sum};
    assign grow_val  = (grow_cand > {2'b00, lim}) ? lim : grow_cand[ffha_pkg::CNT_W-1:0];

    // usable payload bytes of the named block
    assign old_less = cur_bsz - ffha_pkg::CNT_W'(1);
    assign usable   = (cur_bsz == '0) ? '0 : {old_less, 4'b0000};

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        size_next         = size_reg;
        off_next          = off_reg;
        u_next            = u_reg;
        units_next        = units_reg;
        p_next            = p_reg;
        hdr_next          = hdr_reg;
        moving_next       = moving_reg;
        res_status_next   = res_status_reg;
        res_off_next      = res_off_reg;
        res_copy_next     = res_copy_reg;
        heap_top_next     = heap_top_reg;
        reserved_end_next = reserved_end_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_data_next       = m_data_reg;
        mem_we            = 1'b0;
        mem_waddr         = AW'(p_reg);
        mem_wdata         = rd_data_reg;
        mem_raddr         = '0;
        start_alloc       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next       = in_op;
                    size_next     = in_size;
                    off_next      = in_off;
                    u_next        = in_u;
                    units_next    = ffha_pkg::units_of(in_size);
                    moving_next   = 1'b0;
                    res_off_next  = '0;
                    res_copy_next = '0;
                    case (in_op)
                        ffha_pkg::OP_ALLOC: begin
                            start_alloc = 1'b1;
                        end
                        ffha_pkg::OP_FREE: begin
                            if (in_ptr_ok) begin
                                mem_raddr  = AW'(in_u);
                                state_next = S_HDR;
                            end else begin
                                // null or bad pointer is ignored
                                res_status_next = ffha_pkg::ST_NULL;
                                state_next      = S_RESP;
                            end
                        end
                        ffha_pkg::OP_RESIZE: begin
                            if (in_off == '0) begin
                                start_alloc = 1'b1;
                            end else if (!in_ptr_ok) begin
                                res_status_next = ffha_pkg::ST_NOMEM;
                                state_next      = S_RESP;
                            end else begin
                                mem_raddr  = AW'(in_u);
                                state_next = S_HDR;
                            end
                        end
                        default: begin
                            res_status_next = ffha_pkg::ST_NULL;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end

            S_HDR: begin
                if (op_reg == ffha_pkg::OP_FREE || size_reg == '0) begin
                    // free, or resize to zero bytes
                    mem_we          = 1'b1;
                    mem_waddr       = AW'(u_reg);
                    mem_wdata       = {cur_bsz, 1'b0};
                    res_status_next = ffha_pkg::ST_NULL;
                    state_next      = S_RESP;
                end else if (size_reg <= usable) begin
                    // block already big enough
                    res_status_next = ffha_pkg::ST_OK;
                    res_off_next    = off_reg;
                    state_next      = S_RESP;
                end else begin
                    hdr_next      = rd_data_reg;
                    moving_next   = 1'b1;
                    res_copy_next = usable[ffha_pkg::COPY_W-1:0];
                    start_alloc   = 1'b1;
                end
            end

            S_SCAN: begin
                if (cur_bsz == '0) begin
                    // broken chain ends the walk
                    state_next = S_BUMP;
                end else if (!cur_used && {1'b0, cur_bsz} >= units_reg) begin
                    mem_we          = 1'b1;
                    mem_waddr       = AW'(p_reg);
                    mem_wdata       = {cur_bsz, 1'b1};
                    res_status_next = ffha_pkg::ST_OK;
                    res_off_next    = ffha_pkg::off_of(p_reg);
                    state_next      = moving_reg ? S_RELEASE : S_RESP;
                end else if (scan_next < {1'b0, heap_top_reg}) begin
                    p_next    = scan_next[ffha_pkg::CNT_W-1:0];
                    mem_raddr = AW'(scan_next[ffha_pkg::CNT_W-1:0]);
                end else begin
                    state_next = S_BUMP;
                end
            end

            S_BUMP: begin
                if (bump_ok) begin
                    mem_we          = 1'b1;
                    mem_waddr       = AW'(heap_top_reg);
                    mem_wdata       = {units_reg[ffha_pkg::CNT_W-1:0], 1'b1};
                    heap_top_next   = need_end[ffha_pkg::CNT_W-1:0];
                    if (need_end > {2'b00, reserved_end_reg}) begin
                        reserved_end_next = grow_val;
                    end
                    res_status_next = ffha_pkg::ST_OK;
                    res_off_next    = ffha_pkg::off_of(heap_top_reg);
                    state_next      = moving_reg ? S_RELEASE : S_RESP;
                end else begin
                    // out of memory, old block of a resize stays used
                    res_status_next = ffha_pkg::ST_NOMEM;
                    res_off_next    = '0;
                    res_copy_next   = '0;
                    state_next      = S_RESP;
                end
            end

            S_RELEASE: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(u_reg);
                mem_wdata  = {hdr_reg[ffha_pkg::HDR_W-1:1], 1'b0};
                state_next = S_RESP;
            end

            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {res_copy_reg, res_off_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // first-fit walk starts at unit 0, or bumps when no block exists
        if (start_alloc) begin
            p_next     = '0;
            mem_raddr  = '0;
            state_next = (heap_top_reg == '0) ? S_BUMP : S_SCAN;
        end
    end

    // configuration writes
    always_comb begin
        limit_next = limit_reg;
        grow_next  = grow_reg;
        if (cfg_we) begin
            case (cfg_index)
                ffha_pkg::REG_HEAP_LIMIT: limit_next = cfg_wdata;
                ffha_pkg::REG_GROW_MIN:   grow_next  = cfg_wdata;
                default: begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            heap_top_reg     <= '0;
            reserved_end_reg <= '0;
            limit_reg        <= ffha_pkg::LIMIT_RST;
            grow_reg         <= ffha_pkg::GROW_RST;
        end else begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            heap_top_reg     <= heap_top_next;
            reserved_end_reg <= reserved_end_next;
            limit_reg        <= limit_next;
            grow_reg         <= grow_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        off_reg        <= off_next;
        u_reg          <= u_next;
        units_reg      <= units_next;
        p_reg          <= p_next;
        hdr_reg        <= hdr_next;
        moving_reg     <= moving_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_copy_reg   <= res_copy_next;
        m_data_reg     <= m_data_next;
    end

    // header memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hdr_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= hdr_mem[mem_raddr];
    end

endmodule

// ----- src/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// port-level checks of the first-fit heap allocator
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ffha_pkg::TDATA_W-1:0] m_tdata
);

    logic [ffha_pkg::STATUS_W-1:0] st;
    logic [ffha_pkg::OFF_W-1:0]    roff;
    logic [ffha_pkg::COPY_W-1:0]   cpy;

    assign st   = m_tdata[1:0];
    assign roff = m_tdata[22:2];
    assign cpy  = m_tdata[42:23];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while busy");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st == ffha_pkg::ST_OK || st == ffha_pkg::ST_NOMEM
                     || st == ffha_pkg::ST_NULL)
        else $error("status code out of range");

    // only a granted block carries an offset or a copy length
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != ffha_pkg::ST_OK |-> roff == '0 && cpy == '0)
        else $error("fields set on a failed or null result");

    a_ok_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ffha_pkg::ST_OK |-> roff[3:0] == 4'd0 && roff != '0)
        else $error("granted offset null or misaligned");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
